// ===== design/png_scanline_unfilter_macros.svh =====
// Assertion macros shared by the queue and back-end modules of the scanline unfilter.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PSU_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define PSU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/psu_pkg.sv =====
// Package: types, constants and helpers of the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

   // Default sizes of the line buffer and the pixel history
   localparam int MAX_ROW_BYTES_DEF   = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 4;

   // Column field wide enough for any supported row length
   localparam int COL_W = 16;

   // Configuration register widths and indexes
   localparam int BPP_W      = 3;
   localparam int ROW_W      = 14;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES       = 1'b1;

   // Command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // Highest known filter type code
   localparam logic [7:0] FILTER_MAX_CODE = 8'd4;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filt_code_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
      logic       unknown_filter;
   } rsp_word_type;

   // One classified data byte, handed from front to back
   typedef struct packed {
      logic [7:0]       data_byte;
      logic [COL_W-1:0] column;
      filt_code_type    filter;
      logic             unknown;
      logic             first_row;
      logic             row_first;
      logic             row_end;
   } cmd_type;

   // Paeth predictor: nearest of a, b, c to a + b - c, ties to a then b
   function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [8:0] pa;
      logic [8:0] pb;
      logic [8:0] pc;
      logic [7:0] res;
      da = signed'({2'b00, b}) - signed'({2'b00, c});
      db = signed'({2'b00, a}) - signed'({2'b00, c});
      dc = signed'({2'b00, a}) + signed'({2'b00, b}) - 10'sd2 * signed'({2'b00, c});
      pa = da[9] ? 9'(-da) : da[8:0];
      pb = db[9] ? 9'(-db) : db[8:0];
      pc = dc[9] ? 9'(-dc) : dc[8:0];
      if (pa <= pb && pa <= pc) begin
         res = a;
      end else if (pb <= pc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

// ===== design/psu_front.sv =====
// Front end: takes stream bytes, tracks row state and issues data-byte commands.
`timescale 1ns / 1ps

module psu_front #(
   parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  psu_pkg::req_word_type req_data,
   input  logic [$clog2(MAX_ROW_BYTES+1)-1:0] row_len,
   input  logic                  q_full,
   output logic                  push_valid,
   output psu_pkg::cmd_type      push_cmd
);
   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

   logic [ADDR_W-1:0]       column_ff, column_in;
   logic                    expect_ff, expect_in;
   logic                    first_row_ff, first_row_in;
   logic                    row_first_ff, row_first_in;
   logic                    unknown_ff, unknown_in;
   psu_pkg::filt_code_type  filter_ff, filter_in;

   logic accept;
   logic is_filter_byte;
   logic last;

   // Stall only on a full queue
   assign req_stall      = q_full;
   assign accept         = req_valid && !req_stall;
   assign is_filter_byte = req_data.image_start || expect_ff;
   assign last           = (32'(column_ff) + 32'd1) >= 32'(row_len);

   // Issue a command for every accepted data byte
   assign push_valid         = accept && !is_filter_byte;
   assign push_cmd.data_byte = req_data.data_byte;
   assign push_cmd.column    = psu_pkg::COL_W'(column_ff);
   assign push_cmd.filter    = filter_ff;
   assign push_cmd.unknown   = unknown_ff;
   assign push_cmd.first_row = first_row_ff;
   assign push_cmd.row_first = row_first_ff;
   assign push_cmd.row_end   = last;

   // Advance row state
   always_comb begin
      column_in    = column_ff;
      expect_in    = expect_ff;
      first_row_in = first_row_ff;
      row_first_in = row_first_ff;
      unknown_in   = unknown_ff;
      filter_in    = filter_ff;
      if (accept) begin
         if (is_filter_byte) begin
            unknown_in   = req_data.data_byte > psu_pkg::FILTER_MAX_CODE;
            filter_in    = unknown_in ? psu_pkg::FILT_NONE
                                      : psu_pkg::filt_code_type'(req_data.data_byte[2:0]);
            column_in    = '0;
            expect_in    = 1'b0;
            row_first_in = 1'b1;
            if (req_data.image_start) begin
               first_row_in = 1'b1;
            end
         end else begin
            row_first_in = 1'b0;
            if (last) begin
               column_in    = '0;
               expect_in    = 1'b1;
               first_row_in = 1'b0;
            end else begin
               column_in = column_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         expect_ff    <= 1'b1;
         first_row_ff <= 1'b1;
         row_first_ff <= 1'b1;
         unknown_ff   <= 1'b0;
         filter_ff    <= psu_pkg::FILT_NONE;
      end else begin
         column_ff    <= column_in;
         expect_ff    <= expect_in;
         first_row_ff <= first_row_in;
         row_first_ff <= row_first_in;
         unknown_ff   <= unknown_in;
         filter_ff    <= filter_in;
      end
   end

endmodule

// ===== design/psu_queue.sv =====
// Command queue: a short FIFO between the front and back ends.
`timescale 1ns / 1ps
`include "png_scanline_unfilter_macros.svh"

module psu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  psu_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             pop_valid,
   output psu_pkg::cmd_type pop_cmd,
   input  logic             pop
);
   psu_pkg::cmd_type                entries_ff [psu_pkg::Q_DEPTH];
   logic [psu_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [psu_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [psu_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   assign full      = count_ff == psu_pkg::Q_CNT_W'(psu_pkg::Q_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + psu_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + psu_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + psu_pkg::Q_CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - psu_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed word
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PSU_ASSERT_SAME(a_push_has_room, clock, reset, push_valid, !full, "push into full queue")
   `PSU_ASSERT_SAME(a_pop_has_data, clock, reset, pop, pop_valid, "pop from empty queue")

endmodule

// ===== design/psu_back.sv =====
// Back end: line buffer read, filter reconstruction and result register.
`timescale 1ns / 1ps
`include "png_scanline_unfilter_macros.svh"

module psu_back #(
   parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  psu_pkg::cmd_type      q_cmd,
   output logic                  q_pop,
   input  logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] bpp_idx,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output psu_pkg::rsp_word_type rsp_data
);
   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

   logic [7:0] line_mem [MAX_ROW_BYTES];

   logic                  s1_valid_ff;
   psu_pkg::cmd_type      s1_cmd_ff;
   logic [7:0]            rdata_ff;
   logic                  byp_ff;
   logic [7:0]            byp_data_ff;
   logic [7:0]            left_ff   [MAX_PIXEL_BYTES];
   logic [7:0]            upleft_ff [MAX_PIXEL_BYTES];
   logic                  rsp_valid_ff;
   psu_pkg::rsp_word_type rsp_data_ff;

   logic              out_free;
   logic              s1_adv;
   logic              load;
   logic [ADDR_W-1:0] s1_addr;
   logic [ADDR_W-1:0] q_addr;
   logic [7:0]        a_val, b_val, c_val;
   logic [8:0]        avg_sum;
   logic [7:0]        pred;
   logic [7:0]        val;

   // Stage handshakes
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign load     = q_valid && (!s1_valid_ff || s1_adv);
   assign q_pop    = load;
   assign s1_addr  = s1_cmd_ff.column[ADDR_W-1:0];
   assign q_addr   = q_cmd.column[ADDR_W-1:0];

   // Gather neighbors; histories read as zero on the first byte of a row
   assign a_val   = s1_cmd_ff.row_first ? 8'd0 : left_ff[bpp_idx];
   assign c_val   = s1_cmd_ff.row_first ? 8'd0 : upleft_ff[bpp_idx];
   assign b_val   = s1_cmd_ff.first_row ? 8'd0 : (byp_ff ? byp_data_ff : rdata_ff);
   assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

   // Select predictor
   always_comb begin
      unique case (s1_cmd_ff.filter)
         psu_pkg::FILT_NONE:  pred = 8'd0;
         psu_pkg::FILT_SUB:   pred = a_val;
         psu_pkg::FILT_UP:    pred = b_val;
         psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pred(a_val, b_val, c_val);
         default:             pred = 8'd0;
      endcase
   end

   assign val = s1_cmd_ff.data_byte + pred;

   // Write the line buffer and read ahead for the next command
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_addr] <= val;
      end
      if (load) begin
         rdata_ff <= line_mem[q_addr];
      end
   end

   // Forward a byte written in the same cycle it is read
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (load) begin
         byp_ff <= s1_adv && (s1_addr == q_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byp_data_ff <= val;
         s1_cmd_ff   <= q_cmd;
      end
   end

   // Hold or advance the read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Shift pixel histories
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= 8'd0;
            upleft_ff[k] <= 8'd0;
         end
      end else if (s1_adv) begin
         for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= s1_cmd_ff.row_first ? 8'd0 : left_ff[k-1];
            upleft_ff[k] <= s1_cmd_ff.row_first ? 8'd0 : upleft_ff[k-1];
         end
         left_ff[0]   <= val;
         upleft_ff[0] <= b_val;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff.pixel_byte     <= val;
         rsp_data_ff.row_end        <= s1_cmd_ff.row_end;
         rsp_data_ff.unknown_filter <= s1_cmd_ff.unknown;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PSU_ASSERT_NEXT(a_adv_fills_out, clock, reset, s1_adv, rsp_valid_ff, "result lost")
   `PSU_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !out_free,
                    s1_valid_ff && $stable(s1_cmd_ff), "read stage dropped a word")

endmodule

// ===== design/png_scanline_unfilter.sv =====
// Top level: configuration registers and the front, queue and back of the unfilter.
`timescale 1ns / 1ps

// PNG scanline unfilter. Each accepted byte of the decompressed stream is a filter
// type byte (first byte of a row, or any byte with image_start) or a data byte;
// data bytes are rebuilt with None, Sub, Up, Average or Paeth, and a row whose
// filter type is above 4 passes its bytes through with unknown_filter set. The
// block takes one byte per cycle when rsp_stall stays low; filter type bytes use
// an input cycle and give no result. A data byte's result passes through the command
// queue, leaving it together with the registered line buffer read, and then the read
// stage, whose reconstruction lands in the result register. The line buffer is a
// single memory of MAX_ROW_BYTES bytes, written and read once per cycle; a byte
// rebuilt in one cycle is forwarded to a read of the same column in that cycle.
// The buffer needs no clearing pass: row zero of each image reads above as zero.
// Write bytes_per_pixel and row_bytes only while no byte is in flight.

module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  psu_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output psu_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_wen,
   input  logic [psu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int LEN_W     = $clog2(MAX_ROW_BYTES + 1);
   localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [psu_pkg::BPP_W-1:0] bpp_ff;
   logic [psu_pkg::ROW_W-1:0] row_ff;

   logic [31:0]          bpp_eff;
   logic [31:0]          row_eff;
   logic [PIX_IDX_W-1:0] bpp_idx;
   logic [LEN_W-1:0]     row_len;

   logic             push_valid;
   psu_pkg::cmd_type push_cmd;
   logic             q_full;
   logic             q_valid;
   psu_pkg::cmd_type q_cmd;
   logic             q_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= psu_pkg::BPP_W'(1);
         row_ff <= psu_pkg::ROW_W'(1);
      end else if (csr_wen) begin
         unique case (csr_index)
            psu_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_wdata[psu_pkg::BPP_W-1:0];
            psu_pkg::CSR_ROW_BYTES:       row_ff <= csr_wdata[psu_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp settings into the supported range
   assign bpp_eff = (bpp_ff == '0) ? 32'd1 :
                    (32'(bpp_ff) > 32'(MAX_PIXEL_BYTES)) ? 32'(MAX_PIXEL_BYTES) :
                    32'(bpp_ff);
   assign row_eff = (row_ff == '0) ? 32'd1 :
                    (32'(row_ff) > 32'(MAX_ROW_BYTES)) ? 32'(MAX_ROW_BYTES) :
                    32'(row_ff);
   assign bpp_idx = PIX_IDX_W'(bpp_eff - 32'd1);
   assign row_len = LEN_W'(row_eff);

   psu_front #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .row_len    (row_len),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   psu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop        (q_pop)
   );

   psu_back #(
      .MAX_ROW_BYTES  (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .bpp_idx   (bpp_idx),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for png_scanline_unfilter: directed and random scanline traffic, scoreboard-checked.
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_WORDS = 1080;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_WORDS   = 64;

   // Tracks the unfilter state and holds the pixels still owed by the block
   class unfilter_scoreboard;
      bit [7:0]                       prev_row [psu_pkg::MAX_ROW_BYTES_DEF];
      bit [7:0]                       left_bytes [psu_pkg::MAX_PIXEL_BYTES_DEF];
      bit [7:0]                       upleft_bytes [psu_pkg::MAX_PIXEL_BYTES_DEF];
      int unsigned                    col;
      psu_pkg::filt_code_type         row_filt;
      bit                             row_unknown;
      bit                             at_filter_byte;
      bit                             in_row_zero;
      bit [psu_pkg::BPP_W-1:0]        bpp_reg;
      bit [psu_pkg::ROW_W-1:0]        len_reg;
      psu_pkg::rsp_word_type          pixel_queue [$];
      int unsigned                    pixels_seen;
      int                             fault_count;

      function new();
         col = 0;
         row_filt = psu_pkg::FILT_NONE;
         row_unknown = 1'b0;
         at_filter_byte = 1'b1;
         in_row_zero = 1'b1;
         bpp_reg = 1;
         len_reg = 1;
         pixels_seen = 0;
         fault_count = 0;
      endfunction

      function void set_register(logic [psu_pkg::CSR_IDX_W-1:0] idx,
                                 logic [psu_pkg::CSR_DATA_W-1:0] value);
         if (idx == psu_pkg::CSR_BYTES_PER_PIXEL) begin
            bpp_reg = value[psu_pkg::BPP_W-1:0];
         end else if (idx == psu_pkg::CSR_ROW_BYTES) begin
            len_reg = value[psu_pkg::ROW_W-1:0];
         end
      endfunction

      // Advance the model by one accepted word and queue the pixel it yields
      function void take_word(psu_pkg::req_word_type w);
         int unsigned           pix_dist;
         int unsigned           len;
         int                    ia, ib, ic, p, pa, pb, pc;
         bit [7:0]              a, b, c, pred, val;
         bit [8:0]              sum9;
         psu_pkg::rsp_word_type want;
         if (w.image_start) begin
            in_row_zero = 1'b1;
            at_filter_byte = 1'b1;
         end
         // filter type word: latch the row's filter and restart the row
         if (at_filter_byte) begin
            row_unknown = w.data_byte > psu_pkg::FILTER_MAX_CODE;
            row_filt = row_unknown ? psu_pkg::FILT_NONE
                                   : psu_pkg::filt_code_type'(w.data_byte[2:0]);
            foreach (left_bytes[k]) begin
               left_bytes[k] = '0;
               upleft_bytes[k] = '0;
            end
            col = 0;
            at_filter_byte = 1'b0;
            return;
         end
         pix_dist = (bpp_reg == 0) ? 1 :
                    (bpp_reg > psu_pkg::MAX_PIXEL_BYTES_DEF) ? psu_pkg::MAX_PIXEL_BYTES_DEF :
                    bpp_reg;
         len = (len_reg == 0) ? 1 :
               (len_reg > psu_pkg::MAX_ROW_BYTES_DEF) ? psu_pkg::MAX_ROW_BYTES_DEF : len_reg;
         a = left_bytes[pix_dist-1];
         c = upleft_bytes[pix_dist-1];
         b = (!in_row_zero && col < psu_pkg::MAX_ROW_BYTES_DEF) ? prev_row[col] : 8'h00;
         case (row_filt)
            psu_pkg::FILT_SUB: begin
               pred = a;
            end
            psu_pkg::FILT_UP: begin
               pred = b;
            end
            psu_pkg::FILT_AVG: begin
               sum9 = {1'b0, a} + {1'b0, b};
               pred = sum9[8:1];
            end
            psu_pkg::FILT_PAETH: begin
               ia = a;
               ib = b;
               ic = c;
               p = ia + ib - ic;
               pa = (p >= ia) ? p - ia : ia - p;
               pb = (p >= ib) ? p - ib : ib - p;
               pc = (p >= ic) ? p - ic : ic - p;
               pred = (pa <= pb && pa <= pc) ? a : (pb <= pc) ? b : c;
            end
            default: begin
               pred = 8'h00;
            end
         endcase
         val = w.data_byte + pred;
         if (col < psu_pkg::MAX_ROW_BYTES_DEF) prev_row[col] = val;
         for (int k = psu_pkg::MAX_PIXEL_BYTES_DEF - 1; k > 0; k--) begin
            left_bytes[k] = left_bytes[k-1];
            upleft_bytes[k] = upleft_bytes[k-1];
         end
         left_bytes[0] = val;
         upleft_bytes[0] = b;
         want.pixel_byte = val;
         want.row_end = (col + 1 >= len);
         want.unknown_filter = row_unknown;
         if (want.row_end) begin
            col = 0;
            at_filter_byte = 1'b1;
            in_row_zero = 1'b0;
         end else begin
            col++;
         end
         pixel_queue = {pixel_queue, want};
      endfunction

      task report_fault(string msg);
         fault_count++;
         $display("%0t mismatch: %s", $time, msg);
      endtask

      // Compare one delivered pixel word with the oldest one owed
      task check_word(psu_pkg::rsp_word_type got);
         psu_pkg::rsp_word_type want;
         pixels_seen++;
         if (pixel_queue.size() == 0) begin
            report_fault($sformatf("pixel %0d (%02h) arrived with nothing owed",
                                   pixels_seen, got.pixel_byte));
            return;
         end
         want = pixel_queue.pop_front();
         if (got.pixel_byte !== want.pixel_byte) begin
            report_fault($sformatf("pixel %0d: pixel_byte %02h, want %02h",
                                   pixels_seen, got.pixel_byte, want.pixel_byte));
         end
         if (got.row_end !== want.row_end) begin
            report_fault($sformatf("pixel %0d: row_end %b, want %b",
                                   pixels_seen, got.row_end, want.row_end));
         end
         if (got.unknown_filter !== want.unknown_filter) begin
            report_fault($sformatf("pixel %0d: unknown_filter %b, want %b",
                                   pixels_seen, got.unknown_filter, want.unknown_filter));
         end
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   psu_pkg::req_word_type          req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   psu_pkg::rsp_word_type          rsp_data;
   logic                           csr_wen = 1'b0;
   logic [psu_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int                    send_gap_pct = 29;
   int                    recv_stall_pct = 46;
   int unsigned           sent_words = 0;
   int unsigned           row_setting = 1;
   int unsigned           cycle_count = 0;
   unfilter_scoreboard    board = new();

   png_scanline_unfilter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Check every pixel word taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) board.check_word(rsp_data);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one word after a random gap and hold it until taken
   task automatic push_word(input logic [7:0] value, input logic start);
      psu_pkg::req_word_type w;
      w.data_byte = value;
      w.image_start = start;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.take_word(w);
      sent_words++;
   endtask

   // Drop valid and wait until nothing is in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers; junk rides in the unused bits of bytes_per_pixel
   task automatic write_regs(input logic [psu_pkg::BPP_W-1:0] bpp,
                             input logic [psu_pkg::ROW_W-1:0] len);
      logic [psu_pkg::CSR_DATA_W-1:0] bpp_word;
      bpp_word = {(psu_pkg::CSR_DATA_W - psu_pkg::BPP_W)'($urandom), bpp};
      csr_wen <= 1'b1;
      csr_index <= psu_pkg::CSR_BYTES_PER_PIXEL;
      csr_wdata <= bpp_word;
      @(posedge clock);
      board.set_register(psu_pkg::CSR_BYTES_PER_PIXEL, bpp_word);
      csr_index <= psu_pkg::CSR_ROW_BYTES;
      csr_wdata <= len;
      @(posedge clock);
      board.set_register(psu_pkg::CSR_ROW_BYTES, len);
      csr_wen <= 1'b0;
      row_setting = len;
   endtask

   // One image of random rows; now and then a row is cut short or restarted
   task automatic random_image();
      int unsigned pick, len, rows, cut_row, cut_at;
      logic [7:0]  filt;
      if ($urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, 15);
         len = (pick == 0) ? 0 : (pick < 12) ? $urandom_range(1, 12) :
               (pick < 15) ? $urandom_range(13, 48) : $urandom_range(49, 200);
         settle();
         write_regs(psu_pkg::BPP_W'($urandom_range(0, 7)), psu_pkg::ROW_W'(len));
      end
      len = (row_setting == 0) ? 1 :
            (row_setting > psu_pkg::MAX_ROW_BYTES_DEF) ? psu_pkg::MAX_ROW_BYTES_DEF :
            row_setting;
      rows = $urandom_range(1, 6);
      cut_row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rows - 1) : rows;
      cut_at = $urandom_range(0, len - 1);
      for (int r = 0; r < rows; r++) begin
         filt = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 4))
                                           : 8'($urandom_range(5, 255));
         push_word(filt, r == 0 || $urandom_range(0, 19) == 0);
         for (int i = 0; i < len; i++) begin
            if (r == cut_row && i == cut_at) return;
            push_word(8'($urandom), $urandom_range(0, 99) == 0);
         end
      end
   endtask

   initial begin
      int unsigned random_base;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every filter on two-byte rows, one byte per pixel
      write_regs(3'd1, 14'd2);
      push_word(8'd1, 1'b1);
      push_word(8'hFF, 1'b0);
      push_word(8'h01, 1'b0);
      push_word(8'd2, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'd3, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'd4, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'h7F, 1'b0);
      push_word(8'd0, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      // unknown filter type passes bytes through
      push_word(8'd200, 1'b0);
      push_word(8'h12, 1'b0);
      push_word(8'h34, 1'b0);
      // image start in the middle of a row
      push_word(8'd3, 1'b0);
      push_word(8'h55, 1'b0);
      push_word(8'd4, 1'b1);
      push_word(8'hAA, 1'b0);

      // zero settings act as one
      settle();
      write_regs(3'd0, 14'd0);
      push_word(8'd1, 1'b1);
      push_word(8'hFE, 1'b0);
      push_word(8'd2, 1'b0);
      push_word(8'h03, 1'b0);

      // widest pixel, then shorten the row while column is already past the new end
      settle();
      write_regs(3'd7, 14'd5);
      push_word(8'd0, 1'b1);
      push_word(8'h00, 1'b0);
      push_word(8'h11, 1'b0);
      push_word(8'h22, 1'b0);
      push_word(8'h33, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'd4, 1'b0);
      push_word(8'h40, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'hC0, 1'b0);
      settle();
      write_regs(3'd7, 14'd2);
      push_word(8'h09, 1'b0);
      push_word(8'd2, 1'b0);
      push_word(8'h01, 1'b0);
      push_word(8'h02, 1'b0);

      // random images, idling shifts from sender-light to receiver-light to none
      random_base = sent_words;
      while (sent_words < random_base + RANDOM_WORDS) begin
         if (sent_words >= random_base + 2 * RANDOM_WORDS / 3) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end else if (sent_words >= random_base + RANDOM_WORDS / 3) begin
            send_gap_pct = 46;
            recv_stall_pct = 29;
         end
         random_image();
      end

      // all-ones row setting clamps to the line buffer size: no early row end
      settle();
      write_regs(3'd4, 14'h3FFF);
      push_word(8'd4, 1'b1);
      repeat (LONG_WORDS) push_word(8'($urandom), 1'b0);

      settle();
      if (board.fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/psu_pkg.sv
design/psu_front.sv
design/psu_queue.sv
design/psu_back.sv
design/png_scanline_unfilter.sv
bench/tb_top.sv
